// ===== design/mupl3_pkg.sv =====
package mupl3_pkg;

  // store geometry
  localparam int STORE_DEPTH = 4096;
  localparam int DATA_BITS   = 64;
  localparam int AW          = $clog2(STORE_DEPTH);

  // field and size widths
  localparam int SIZE_W  = 13;
  localparam int CNT_W   = 12;
  localparam int PM_W    = CNT_W + SIZE_W;
  localparam int BASE_W  = PM_W + 1;
  localparam int M1_W    = AW + SIZE_W;
  localparam int SUM_W   = ((M1_W > PM_W) ? M1_W : PM_W) + 2;

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(4096);

  // request codes
  localparam logic CMD_SCATTER = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // layout codes
  localparam logic LAYOUT_NCDHW = 1'b0;
  localparam logic LAYOUT_NDHWC = 1'b1;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BATCH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_PLANE_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_PLANE_SIZE = 3'd4;

  // clamped sizes seen by the datapath
  typedef struct packed {
    logic              layout;
    logic [SIZE_W-1:0] n_lim;
    logic [SIZE_W-1:0] c_lim;
    logic [SIZE_W-1:0] i_lim;
    logic [SIZE_W-1:0] p_lim;
  } mupl3_cfg_t;

  // accepted request with its counter snapshot
  typedef struct packed {
    logic                 cmd;
    logic [DATA_BITS-1:0] value;
    logic [31:0]          argmax;
    logic [CNT_W-1:0]     raddr;
    logic [CNT_W-1:0]     n;
    logic [CNT_W-1:0]     c;
    logic                 done;
  } mupl3_item_t;

  // payload carried down the address pipeline
  typedef struct packed {
    logic                 cmd;
    logic [DATA_BITS-1:0] value;
    logic [CNT_W-1:0]     raddr;
    logic [CNT_W-1:0]     c;
    logic [CNT_W-1:0]     idx;
    logic                 bad_arg;
    logic                 done;
  } mupl3_stg_t;

  // store access for one request
  typedef struct packed {
    logic                 valid;
    logic                 wr_en;
    logic [AW-1:0]        waddr;
    logic [DATA_BITS-1:0] wdata;
    logic [AW-1:0]        raddr;
    logic                 sel;
    logic                 bad;
    logic                 done;
  } mupl3_req_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return SIZE_W'(1);
    end else if (v > SIZE_MAX) begin
      return SIZE_MAX;
    end else begin
      return v;
    end
  endfunction

endpackage

// ===== design/max_unpool_3d_scatter.sv =====
// max unpooling scatter engine for 3d tensors. a request is taken at a clock edge with start
// high and busy low, one request per cycle, and its result shows on the out_ ports
// for one cycle under out_valid: one stage captures the request and steps the batch,
// channel and position counters, three stages form the store address (batch times
// channels, then times the output plane size), and the last edge writes or reads the
// 4096-entry output store and registers the result. the receiver cannot stall, so
// results come out in request order at the request rate. after reset the store is
// swept to zero one entry a cycle, so busy stays high until every entry is cleared;
// configuration writes are taken during that sweep. a scatter request whose argmax
// is negative, not below the output plane size, or lands past the store raises
// out_bad_index and writes nothing; the counters step regardless. a read request
// returns the entry and clears it. configuration should be written only when no
// request is in flight.
module max_unpool_3d_scatter
  import mupl3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_cmd,
  input  logic [63:0]          in_value,
  input  logic signed [31:0]   in_argmax,
  input  logic [11:0]          in_read_addr,
  // result channel
  output logic                 out_valid,
  output logic [63:0]          out_read_data,
  output logic                 out_bad_index,
  output logic                 out_tensor_done,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  logic              layout_r;
  logic [SIZE_W-1:0] num_batch_r, num_channels_r, in_plane_size_r, out_plane_size_r;
  mupl3_cfg_t        cfg;
  logic              accept;
  logic              item_valid;
  mupl3_item_t       item;
  mupl3_req_t        req;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r         <= LAYOUT_NCDHW;
      num_batch_r      <= SIZE_W'(1);
      num_channels_r   <= SIZE_W'(1);
      in_plane_size_r  <= SIZE_W'(1);
      out_plane_size_r <= SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAYOUT:         layout_r         <= cfg_data[0];
        CFG_NUM_BATCH:      num_batch_r      <= cfg_data;
        CFG_NUM_CHANNELS:   num_channels_r   <= cfg_data;
        CFG_IN_PLANE_SIZE:  in_plane_size_r  <= cfg_data;
        CFG_OUT_PLANE_SIZE: out_plane_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero reads as one, anything above 4096 as 4096
  always_comb begin
    cfg.layout = layout_r;
    cfg.n_lim  = clamp_size(num_batch_r);
    cfg.c_lim  = clamp_size(num_channels_r);
    cfg.i_lim  = clamp_size(in_plane_size_r);
    cfg.p_lim  = clamp_size(out_plane_size_r);
  end

  assign accept = start && !busy;

  // request capture and running counters
  mupl3_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cmd        (in_cmd),
    .value      (DATA_BITS'(in_value)),
    .argmax     (in_argmax),
    .raddr      (in_read_addr),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item)
  );

  // address pipeline
  mupl3_addr u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .req        (req)
  );

  // output store, clearing sweep and result register
  mupl3_store u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .busy          (busy),
    .res_valid     (out_valid),
    .res_read_data (out_read_data),
    .res_bad       (out_bad_index),
    .res_done      (out_tensor_done)
  );

  // the sweep only runs with an empty pipeline
  a_no_result_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) busy |-> !out_valid
  ) else $error("result strobe during clearing sweep");

  // fixed latency from acceptance to result
  a_latency: assert property (
    @(posedge clk) disable iff (!rst_n) (start && !busy) |=> ##4 out_valid
  ) else $error("accepted request produced no result five cycles later");

  // every strobe traces back to an accepted request
  a_no_invented_result: assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |-> $past(start && !busy, 5)
  ) else $error("result strobe without a matching request");

  // read data and the tensor-done flag only appear under the strobe
  a_quiet_outputs: assert property (
    @(posedge clk) disable iff (!rst_n)
      ((out_read_data != '0) || out_tensor_done) |-> out_valid
  ) else $error("result fields active without strobe");

endmodule

// ===== design/mupl3_seq.sv =====
module mupl3_seq
  import mupl3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 cmd,
  input  logic [DATA_BITS-1:0] value,
  input  logic [31:0]          argmax,
  input  logic [CNT_W-1:0]     raddr,
  input  mupl3_cfg_t           cfg,
  output logic                 item_valid,
  output mupl3_item_t          item
);

  logic [CNT_W-1:0] batch_r, chan_r, pos_r;
  logic [CNT_W-1:0] batch_nxt, chan_nxt, pos_nxt;
  logic [CNT_W:0]   sb, sc, sp;
  logic             wb, wc, wp;
  logic             item_valid_r;
  mupl3_item_t      item_r;

  // returns {wrapped, next count}
  function automatic logic [CNT_W:0] step_cnt(input logic [CNT_W-1:0] cnt,
                                               input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] inc;
    inc = SIZE_W'(cnt) + SIZE_W'(1);
    if (inc >= lim) begin
      return {1'b1, {CNT_W{1'b0}}};
    end else begin
      return {1'b0, inc[CNT_W-1:0]};
    end
  endfunction

  always_comb begin
    sb = step_cnt(batch_r, cfg.n_lim);
    sc = step_cnt(chan_r, cfg.c_lim);
    sp = step_cnt(pos_r, cfg.i_lim);
    wb = sb[CNT_W];
    wc = sc[CNT_W];
    wp = sp[CNT_W];
    if (cfg.layout == LAYOUT_NCDHW) begin
      pos_nxt  = sp[CNT_W-1:0];
      chan_nxt = wp ? sc[CNT_W-1:0] : chan_r;
    end else begin
      chan_nxt = sc[CNT_W-1:0];
      pos_nxt  = wc ? sp[CNT_W-1:0] : pos_r;
    end
    batch_nxt = (wp && wc) ? sb[CNT_W-1:0] : batch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r      <= '0;
      chan_r       <= '0;
      pos_r        <= '0;
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= accept;
      if (accept && cmd == CMD_SCATTER) begin
        batch_r <= batch_nxt;
        chan_r  <= chan_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

  // counter snapshot taken before the step
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd    <= cmd;
      item_r.value  <= value;
      item_r.argmax <= argmax;
      item_r.raddr  <= raddr;
      item_r.n      <= batch_r;
      item_r.c      <= chan_r;
      item_r.done   <= (cmd == CMD_SCATTER) && wp && wc && wb;
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

// ===== design/mupl3_addr.sv =====
module mupl3_addr
  import mupl3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mupl3_cfg_t  cfg,
  input  logic        item_valid,
  input  mupl3_item_t item,
  output mupl3_req_t  req
);

  mupl3_stg_t        s2_r, s3_r, s4_r;
  logic              s2_valid_r, s3_valid_r, s4_valid_r;
  logic [PM_W-1:0]   s2_pm_r;
  logic [AW-1:0]     s3_base_r;
  logic              s3_over_r, s4_over_r;
  logic [M1_W-1:0]   s4_m1_r;
  logic [PM_W-1:0]   s4_m2_r;

  mupl3_stg_t        s2_nxt;
  logic [PM_W-1:0]   pm_nxt;
  logic [BASE_W-1:0] base_nxt;
  logic              over_nxt;
  logic [M1_W-1:0]   m1_nxt;
  logic [PM_W-1:0]   m2_nxt;
  logic [SIZE_W-1:0] idx_mul;
  logic [SUM_W-1:0]  addr_sum;
  logic              rd_ok;
  logic              scat_bad;

  // stage 2: range check on argmax, batch times channels
  always_comb begin
    s2_nxt.cmd     = item.cmd;
    s2_nxt.value   = item.value;
    s2_nxt.raddr   = item.raddr;
    s2_nxt.c       = item.c;
    s2_nxt.idx     = item.argmax[CNT_W-1:0];
    s2_nxt.bad_arg = item.argmax[31] || ({1'b0, item.argmax[30:0]} >= 32'(cfg.p_lim));
    s2_nxt.done    = item.done;
    pm_nxt         = PM_W'(item.n) * PM_W'(cfg.c_lim);
  end

  // stage 3: plane number, overflow past the store
  always_comb begin
    base_nxt = BASE_W'(s2_pm_r)
             + BASE_W'((cfg.layout == LAYOUT_NCDHW) ? s2_r.c : '0);
    over_nxt = base_nxt >= BASE_W'(STORE_DEPTH);
  end

  // stage 4: plane offset and position offset
  always_comb begin
    idx_mul = (cfg.layout == LAYOUT_NDHWC) ? cfg.c_lim : SIZE_W'(1);
    m1_nxt  = M1_W'(s3_base_r) * M1_W'(cfg.p_lim);
    m2_nxt  = PM_W'(s3_r.idx) * PM_W'(idx_mul);
  end

  // final sum and store access
  always_comb begin
    addr_sum = SUM_W'(s4_m1_r) + SUM_W'(s4_m2_r)
             + SUM_W'((cfg.layout == LAYOUT_NDHWC) ? s4_r.c : '0);
    scat_bad = s4_r.bad_arg || s4_over_r || (addr_sum >= SUM_W'(STORE_DEPTH));
    rd_ok    = 32'(s4_r.raddr) < 32'(STORE_DEPTH);
    req.valid = s4_valid_r;
    req.raddr = AW'(s4_r.raddr);
    req.done  = s4_valid_r && s4_r.done;
    if (s4_r.cmd == CMD_READ) begin
      req.wr_en = s4_valid_r && rd_ok;
      req.waddr = AW'(s4_r.raddr);
      req.wdata = '0;
      req.sel   = s4_valid_r && rd_ok;
      req.bad   = !rd_ok;
    end else begin
      req.wr_en = s4_valid_r && !scat_bad;
      req.waddr = addr_sum[AW-1:0];
      req.wdata = s4_r.value;
      req.sel   = 1'b0;
      req.bad   = scat_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= item_valid;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r      <= s2_nxt;
    s2_pm_r   <= pm_nxt;
    s3_r      <= s2_r;
    s3_base_r <= base_nxt[AW-1:0];
    s3_over_r <= over_nxt;
    s4_r      <= s3_r;
    s4_m1_r   <= m1_nxt;
    s4_m2_r   <= m2_nxt;
    s4_over_r <= s3_over_r;
  end

endmodule

// ===== design/mupl3_store.sv =====
module mupl3_store
  import mupl3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mupl3_req_t  req,
  output logic        busy,
  output logic        res_valid,
  output logic [63:0] res_read_data,
  output logic        res_bad,
  output logic        res_done
);

  logic [DATA_BITS-1:0] mem [STORE_DEPTH];
  logic [DATA_BITS-1:0] rd_r;
  logic                 clr_active_r;
  logic [AW-1:0]        clr_addr_r;
  logic                 res_valid_r, res_bad_r, res_done_r, res_sel_r;
  logic                 we;
  logic [AW-1:0]        wa;
  logic [DATA_BITS-1:0] wd;

  // clearing sweep owns the write port after reset
  always_comb begin
    if (clr_active_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end else begin
      we = req.valid && req.wr_en;
      wa = req.waddr;
      wd = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(STORE_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_bad_r  <= req.bad;
    res_done_r <= req.done;
    res_sel_r  <= req.sel;
  end

  assign busy          = clr_active_r;
  assign res_valid     = res_valid_r;
  assign res_bad       = res_bad_r;
  assign res_done      = res_done_r;
  assign res_read_data = res_sel_r ? 64'(rd_r) : '0;

endmodule
